// File: rtl/mcsod_pkg.sv
// Package for the multi-chain shift-out driver.
// Holds the field widths, the command codes and the store write control struct.
// No dependencies.
`default_nettype none

package mcsod_pkg;

  localparam int N_REGS_DEF   = 4;
  localparam int CHAINS_DEF   = 4;

  localparam int CFG_W        = 3;
  localparam logic [CFG_W-1:0] CFG_LEN_RESET = 3'd4;

  localparam int CMD_W        = 2;
  localparam int CHAIN_W      = 2;
  localparam int BIT_IDX_W    = 5;
  localparam int REG_IDX_W    = 2;
  localparam int BYTE_W       = 8;
  localparam int DATA_LINES_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_BIT  = 2'd0,
    CMD_WR_BYTE  = 2'd1,
    CMD_FILL     = 2'd2,
    CMD_LOAD     = 2'd3
  } cmd_t;

  // One write to the byte image. The bit and byte enables are already qualified by range.
  typedef struct packed {
    logic                 bit_en;
    logic                 byte_en;
    logic                 fill_en;
    logic [CHAIN_W-1:0]   chain;
    logic [REG_IDX_W-1:0] reg_sel;
    logic [2:0]           bit_pos;
    logic [BYTE_W-1:0]    value;
  } wr_ctl_t;

endpackage

`default_nettype wire

// File: rtl/mcsod_store.sv
// Byte image of all chains, held in flip-flops and cleared at reset.
// Takes one write per cycle and returns one byte of every chain at a read index.
// Depends on mcsod_pkg.
`default_nettype none

module mcsod_store #(
  parameter int N_REGS = mcsod_pkg::N_REGS_DEF,
  parameter int CHAINS = mcsod_pkg::CHAINS_DEF,
  localparam int RIW   = (N_REGS > 1) ? $clog2(N_REGS) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mcsod_pkg::wr_ctl_t       wr,
  input  wire logic [RIW-1:0]           rd_idx,
  output logic [CHAINS-1:0][7:0]        rd_bytes
);

  logic [CHAINS-1:0][N_REGS-1:0][7:0] store_r;
  logic [CHAINS-1:0][N_REGS-1:0][7:0] store_nxt;

  always_comb begin
    store_nxt = store_r;
    for (int c = 0; c < CHAINS; c++) begin
      for (int r = 0; r < N_REGS; r++) begin
        if (wr.fill_en) begin
          store_nxt[c][r] = (wr.value != 8'd0) ? 8'hFF : 8'h00;
        end else if ((4'(wr.chain) == 4'(c)) && (4'(wr.reg_sel) == 4'(r))) begin
          if (wr.byte_en) begin
            store_nxt[c][r] = wr.value;
          end else if (wr.bit_en) begin
            store_nxt[c][r][wr.bit_pos] = (wr.value != 8'd0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
    end else begin
      store_r <= store_nxt;
    end
  end

  always_comb begin
    for (int c = 0; c < CHAINS; c++) begin
      rd_bytes[c] = store_r[c][rd_idx];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mcsod_shifter.sv
// One 8-bit shift register per data line, loaded with a byte of each chain
// and shifted out MSB first. Depends on mcsod_pkg.
`default_nettype none

module mcsod_shifter #(
  parameter int CHAINS = mcsod_pkg::CHAINS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   load,
  input  wire logic                                   shift,
  input  wire logic [CHAINS-1:0][7:0]                 bytes_in,
  output logic [mcsod_pkg::DATA_LINES_W-1:0]          msb_bits
);

  // Chains beyond the data lines are never seen, so they get no lane.
  localparam int NL = (CHAINS < mcsod_pkg::DATA_LINES_W) ? CHAINS
                                                         : mcsod_pkg::DATA_LINES_W;

  logic [NL-1:0][7:0] lane_r;
  logic [NL-1:0][7:0] lane_nxt;

  always_comb begin
    lane_nxt = lane_r;
    for (int l = 0; l < NL; l++) begin
      if (load) begin
        lane_nxt[l] = bytes_in[l];
      end else if (shift) begin
        lane_nxt[l] = {lane_r[l][6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  always_comb begin
    msb_bits = '0;
    for (int l = 0; l < NL; l++) begin
      msb_bits[l] = lane_r[l][7];
    end
  end

endmodule

`default_nettype wire

// File: rtl/multi_chain_shift_out_driver_unit.sv
// Multi-chain shift-out driver: top level with the command decode, the load
// sequencer and the output register. Depends on mcsod_pkg, mcsod_store, mcsod_shifter.
//
// Use: commands arrive as beats on the in_ channel (kind in in_tuser). Bit, byte
// and fill writes update the byte image and produce no beat.
// A load plays out chain_length*8 shift beats, one data bit per chain in
// out_tdata, from the highest register in use down and MSB first, and then one
// latch beat with out_tlast high. The per-chain 8-bit shifters give one bit a
// cycle whenever the output register can take a beat. Writes are accepted
// every cycle while no load is playing out. While a load is playing out
// in_tready is low; it returns high once the latch beat sits in the output
// register. When out_tready is low the output register holds its beat and the
// sequence pauses without loss. cfg_ready is always high; chain_length is
// saturated to 1..N_REGS. Reset clears the image, sets chain_length to 4 and
// empties the output register.
`default_nettype none

module multi_chain_shift_out_driver_unit #(
  parameter int N_REGS = mcsod_pkg::N_REGS_DEF,
  parameter int CHAINS = mcsod_pkg::CHAINS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // chain_sel[1:0], bit_index[6:2], reg_index[8:7],
                                      // write_value[16:9], zero fill above
  input  wire logic [1:0]  in_tuser,  // cmd[1:0]
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // data_lines[3:0], zero fill above
  output logic [1:0]       out_tuser, // shift_pulse[0], latch_pulse[1]
  output logic             out_tlast,
  // Configuration.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data   // chain_length
);

  localparam int RIW = (N_REGS > 1) ? $clog2(N_REGS) : 1;
  localparam int DW  = mcsod_pkg::DATA_LINES_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_LATCH = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [mcsod_pkg::CFG_W-1:0]     cfg_len_r;
  logic [RIW-1:0]                  reg_cnt_r, reg_cnt_nxt;
  logic [2:0]                      bit_cnt_r, bit_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [DW-1:0]                   out_data_r, out_data_nxt;
  logic                            out_shift_r, out_shift_nxt;
  logic                            out_latch_r, out_latch_nxt;

  mcsod_pkg::cmd_t                 cmd;
  logic [mcsod_pkg::CHAIN_W-1:0]   chain_sel;
  logic [mcsod_pkg::BIT_IDX_W-1:0] bit_index;
  logic [mcsod_pkg::REG_IDX_W-1:0] reg_index;
  logic [7:0]                      write_value;
  logic                            in_acc;
  logic [mcsod_pkg::CFG_W-1:0]     eff_len;
  logic [RIW-1:0]                  len_m1;
  logic                            chain_ok;
  mcsod_pkg::wr_ctl_t              wr;
  logic [RIW-1:0]                  rd_idx;
  logic [CHAINS-1:0][7:0]          rd_bytes;
  logic                            slot_free;
  logic                            sh_load;
  logic                            sh_shift;
  logic [DW-1:0]                   msb_bits;

  assign cmd         = mcsod_pkg::cmd_t'(in_tuser);
  assign chain_sel   = in_tdata[1:0];
  assign bit_index   = in_tdata[6:2];
  assign reg_index   = in_tdata[8:7];
  assign write_value = in_tdata[16:9];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= mcsod_pkg::CFG_LEN_RESET;
    end else if (cfg_valid) begin
      cfg_len_r <= cfg_data;
    end
  end

  always_comb begin
    if (cfg_len_r == '0) begin
      eff_len = mcsod_pkg::CFG_W'(1);
    end else if (cfg_len_r > mcsod_pkg::CFG_W'(N_REGS)) begin
      eff_len = mcsod_pkg::CFG_W'(N_REGS);
    end else begin
      eff_len = cfg_len_r;
    end
  end
  assign len_m1 = RIW'(eff_len - mcsod_pkg::CFG_W'(1));

  assign chain_ok = (4'(chain_sel) < 4'(CHAINS));

  always_comb begin
    wr.bit_en  = in_acc && (cmd == mcsod_pkg::CMD_SET_BIT) && chain_ok
                 && ({1'b0, bit_index[4:3]} < eff_len);
    wr.byte_en = in_acc && (cmd == mcsod_pkg::CMD_WR_BYTE) && chain_ok
                 && ({1'b0, reg_index} < eff_len);
    wr.fill_en = in_acc && (cmd == mcsod_pkg::CMD_FILL);
    wr.chain   = chain_sel;
    wr.reg_sel = (cmd == mcsod_pkg::CMD_SET_BIT) ? bit_index[4:3] : reg_index;
    wr.bit_pos = bit_index[2:0];
    wr.value   = write_value;
  end

  // The first byte comes from the top register; later ones one register lower.
  assign rd_idx   = (state_r == ST_IDLE) ? len_m1 : reg_cnt_r - RIW'(1);
  assign sh_shift = (state_r == ST_SHIFT) && slot_free;
  assign sh_load  = (in_acc && (cmd == mcsod_pkg::CMD_LOAD))
                    || (sh_shift && (bit_cnt_r == 3'd7) && (reg_cnt_r != '0));

  mcsod_store #(
    .N_REGS (N_REGS),
    .CHAINS (CHAINS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_idx   (rd_idx),
    .rd_bytes (rd_bytes)
  );

  mcsod_shifter #(
    .CHAINS (CHAINS)
  ) u_shifter (
    .clk      (clk),
    .load     (sh_load),
    .shift    (sh_shift),
    .bytes_in (rd_bytes),
    .msb_bits (msb_bits)
  );

  always_comb begin
    state_nxt   = state_r;
    reg_cnt_nxt = reg_cnt_r;
    bit_cnt_nxt = bit_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (cmd == mcsod_pkg::CMD_LOAD)) begin
          state_nxt   = ST_SHIFT;
          reg_cnt_nxt = len_m1;
          bit_cnt_nxt = 3'd0;
        end
      end
      ST_SHIFT: begin
        if (slot_free) begin
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          if (bit_cnt_r == 3'd7) begin
            if (reg_cnt_r == '0) begin
              state_nxt = ST_LATCH;
            end else begin
              reg_cnt_nxt = reg_cnt_r - RIW'(1);
            end
          end
        end
      end
      ST_LATCH: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_shift_nxt = out_shift_r;
    out_latch_nxt = out_latch_r;
    if (slot_free) begin
      out_valid_nxt = 1'b0;
      if (state_r == ST_SHIFT) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = msb_bits;
        out_shift_nxt = 1'b1;
        out_latch_nxt = 1'b0;
      end else if (state_r == ST_LATCH) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_shift_nxt = 1'b0;
        out_latch_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      reg_cnt_r   <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reg_cnt_r   <= reg_cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_shift_r <= out_shift_nxt;
    out_latch_r <= out_latch_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - DW){1'b0}}, out_data_r};
  assign out_tuser  = {out_latch_r, out_shift_r};
  assign out_tlast  = out_latch_r;

endmodule

`default_nettype wire

// File: tb/sv/tb_multi_chain_shift_out_driver_unit.sv
// Self-checking testbench for the multi-chain shift-out driver.
// It predicts every shift and latch beat from its own copy of the byte image.
// Depends on mcsod_pkg and multi_chain_shift_out_driver_unit.
module tb_multi_chain_shift_out_driver_unit;

  localparam int N_REGS     = mcsod_pkg::N_REGS_DEF;
  localparam int CHAINS     = mcsod_pkg::CHAINS_DEF;
  localparam int STORE_SIZE = N_REGS * CHAINS;

  typedef struct packed {
    logic [mcsod_pkg::DATA_LINES_W-1:0] lines;
    logic                               shift;
    logic                               latch;
    logic                               tail;
  } shift_beat_t;

  // Keeps the predicted byte image and the beats that a load is still owed.
  class shift_image_scoreboard;
    logic [7:0]     image [STORE_SIZE];
    logic [2:0]     length_reg;
    shift_beat_t    beat_q[$];
    int             errors;

    function new();
      foreach (image[i]) image[i] = 8'h00;
      length_reg = mcsod_pkg::CFG_LEN_RESET;
      errors     = 0;
    endfunction

    function void set_length(logic [2:0] v);
      length_reg = v;
    endfunction

    function int pending();
      return beat_q.size();
    endfunction

    function void note_cmd(mcsod_pkg::cmd_t cmd, logic [1:0] chain, logic [4:0] bidx,
                           logic [1:0] ridx, logic [7:0] val);
      int          len;
      int          pos;
      int          reg_no;
      int          bit_no;
      shift_beat_t b;
      len = int'(length_reg);
      if (len < 1) len = 1;
      if (len > N_REGS) len = N_REGS;
      case (cmd)
        mcsod_pkg::CMD_SET_BIT: begin
          reg_no = int'(bidx[4:3]);
          if (int'(chain) < CHAINS && reg_no < len) begin
            pos = int'(chain) * N_REGS + reg_no;
            image[pos][bidx[2:0]] = (val != 8'd0);
          end
        end
        mcsod_pkg::CMD_WR_BYTE: begin
          if (int'(chain) < CHAINS && int'(ridx) < len) begin
            image[int'(chain) * N_REGS + int'(ridx)] = val;
          end
        end
        mcsod_pkg::CMD_FILL: begin
          foreach (image[i]) image[i] = (val != 8'd0) ? 8'hFF : 8'h00;
        end
        mcsod_pkg::CMD_LOAD: begin
          // Highest register in use first, MSB first within each byte.
          for (int step = 0; step < len * 8; step++) begin
            reg_no = (len - 1) - (step >> 3);
            bit_no = 7 - (step & 7);
            b = '0;
            for (int c = 0; c < CHAINS && c < mcsod_pkg::DATA_LINES_W; c++)
              b.lines[c] = image[c * N_REGS + reg_no][bit_no];
            b.shift = 1'b1;
            beat_q.push_back(b);
          end
          b = '0;
          b.latch = 1'b1;
          b.tail  = 1'b1;
          beat_q.push_back(b);
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic [7:0] tdata, logic [1:0] tuser, logic tlast);
      shift_beat_t want;
      if (beat_q.size() == 0) begin
        $error("unexpected beat: data_lines %0h shift %0b latch %0b last %0b",
               tdata[3:0], tuser[0], tuser[1], tlast);
        errors++;
        return;
      end
      want = beat_q.pop_front();
      if (tdata[3:0] !== want.lines) begin
        $error("data_lines: expected %0h, actual %0h", want.lines, tdata[3:0]);
        errors++;
      end
      if (tuser[0] !== want.shift) begin
        $error("shift_pulse: expected %0b, actual %0b", want.shift, tuser[0]);
        errors++;
      end
      if (tuser[1] !== want.latch) begin
        $error("latch_pulse: expected %0b, actual %0b", want.latch, tuser[1]);
        errors++;
      end
      if (tlast !== want.tail) begin
        $error("last: expected %0b, actual %0b", want.tail, tlast);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // chain_sel[1:0], bit_index[6:2], reg_index[8:7],
                           // write_value[16:9], zero fill above
  logic [1:0]  in_tuser;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // data_lines[3:0], zero fill above
  logic [1:0]  out_tuser;  // shift_pulse[0], latch_pulse[1]
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_data;   // chain_length

  bit          tx_idle_on;
  bit          rx_idle_on;
  int          rx_hold_left;

  shift_image_scoreboard sb;

  multi_chain_shift_out_driver_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when the stimulus asks for one.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_tready = 1'b0;
        rx_hold_left--;
      end else begin
        out_tready = !(rx_idle_on && $urandom_range(99) < 27);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser, out_tlast);
  end

  task automatic offer_cmd(input mcsod_pkg::cmd_t cmd, input logic [1:0] chain,
                           input logic [4:0] bidx, input logic [1:0] ridx,
                           input logic [7:0] val);
    @(negedge clk);
    while (tx_idle_on && $urandom_range(99) < 27) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = cmd;
    in_tdata  = {7'd0, val, ridx, bidx, chain};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_cmd(cmd, chain, bidx, ridx, val);
  endtask

  // Mostly writes with random content, with a load now and then to play the image out.
  task automatic random_cmds(input int count);
    int              r;
    mcsod_pkg::cmd_t cmd;
    logic [7:0]      val;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 35)      cmd = mcsod_pkg::CMD_SET_BIT;
      else if (r < 65) cmd = mcsod_pkg::CMD_WR_BYTE;
      else if (r < 72) cmd = mcsod_pkg::CMD_FILL;
      else             cmd = mcsod_pkg::CMD_LOAD;
      val = 8'($urandom_range(255));
      if (cmd != mcsod_pkg::CMD_WR_BYTE && $urandom_range(1) == 0) val = 8'd0;
      offer_cmd(cmd, 2'($urandom_range(3)), 5'($urandom_range(31)),
                2'($urandom_range(3)), val);
    end
  endtask

  // Stops offering commands and waits until every owed beat has come out.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_length(input logic [2:0] v);
    wait_idle();
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_length(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [2:0] lengths [8];
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = mcsod_pkg::CMD_SET_BIT;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    rx_hold_left = 0;
    lengths      = '{3'd2, 3'd1, 3'd3, 3'd5, 3'd0, 3'd6, 3'd7, 3'd4};
    sb = new();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset length of four registers.
    offer_cmd(mcsod_pkg::CMD_LOAD, 2'd0, 5'd0, 2'd0, 8'd0);
    offer_cmd(mcsod_pkg::CMD_FILL, 2'd0, 5'd0, 2'd0, 8'd1);
    offer_cmd(mcsod_pkg::CMD_LOAD, 2'd0, 5'd0, 2'd0, 8'd0);
    offer_cmd(mcsod_pkg::CMD_FILL, 2'd3, 5'd31, 2'd3, 8'd0);
    offer_cmd(mcsod_pkg::CMD_WR_BYTE, 2'd0, 5'd0, 2'd3, 8'h80);
    offer_cmd(mcsod_pkg::CMD_WR_BYTE, 2'd3, 5'd0, 2'd0, 8'h01);
    offer_cmd(mcsod_pkg::CMD_WR_BYTE, 2'd1, 5'd0, 2'd2, 8'hA5);
    offer_cmd(mcsod_pkg::CMD_WR_BYTE, 2'd2, 5'd0, 2'd1, 8'h5A);
    offer_cmd(mcsod_pkg::CMD_SET_BIT, 2'd2, 5'd31, 2'd0, 8'hFF);
    offer_cmd(mcsod_pkg::CMD_SET_BIT, 2'd1, 5'd16, 2'd0, 8'd0);
    offer_cmd(mcsod_pkg::CMD_SET_BIT, 2'd0, 5'd0, 2'd0, 8'd1);
    offer_cmd(mcsod_pkg::CMD_LOAD, 2'd0, 5'd0, 2'd0, 8'd0);

    // One register in use: writes above it are dropped.
    write_length(3'd1);
    offer_cmd(mcsod_pkg::CMD_WR_BYTE, 2'd0, 5'd0, 2'd2, 8'hFF);
    offer_cmd(mcsod_pkg::CMD_SET_BIT, 2'd3, 5'd9, 2'd0, 8'd1);
    offer_cmd(mcsod_pkg::CMD_SET_BIT, 2'd3, 5'd7, 2'd0, 8'd1);
    offer_cmd(mcsod_pkg::CMD_LOAD, 2'd0, 5'd0, 2'd0, 8'd0);
    // Zero saturates to one and seven to the maximum; contents survive the change.
    write_length(3'd0);
    offer_cmd(mcsod_pkg::CMD_LOAD, 2'd0, 5'd0, 2'd0, 8'd0);
    write_length(3'd7);
    offer_cmd(mcsod_pkg::CMD_LOAD, 2'd0, 5'd0, 2'd0, 8'd0);

    foreach (lengths[i]) begin
      write_length(lengths[i]);
      random_cmds(20);
    end

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_cmds(30);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // The receiver holds off while loads keep coming, so the block backs up.
    wait_idle();
    @(posedge clk);
    rx_hold_left = 150;
    for (int i = 0; i < 5; i++) begin
      offer_cmd(mcsod_pkg::CMD_LOAD, 2'd0, 5'd0, 2'd0, 8'd0);
      random_cmds(3);
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
